// File: design/arpc_pkg.sv
// arpc_pkg: request/result types, command/status structs and constants of the arp cache
`default_nettype none
package arpc_pkg;

  // field widths
  localparam int LEN_W = 11;
  localparam int OP_W  = 16;
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // frames shorter than this are dropped
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(42);
  // arp operation code for who-has
  localparam logic [OP_W-1:0]  OP_REQUEST    = OP_W'(1);

  // request kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // one request on the input channel
  typedef struct packed {
    logic             kind;
    logic [LEN_W-1:0] frame_length;
    logic [OP_W-1:0]  opcode;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  tgt_ip;
    logic [IP_W-1:0]  query_ip;
  } in_t;

  // one result on the output channel
  typedef struct packed {
    logic             reply_valid;
    logic [MAC_W-1:0] reply_mac;
    logic [IP_W-1:0]  reply_ip;
    logic             lookup_hit;
    logic [MAC_W-1:0] lookup_mac;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request and restart the table scan
    logic scan;    // step the table scan
    logic update;  // learn and build the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage
`default_nettype wire

// File: design/arp_cache_and_responder.sv
// arp_cache_and_responder: top level of the arp cache and who-has responder
`default_nettype none
// Takes one request at a time: a parsed arp frame or a lookup query. The
// table is held in a memory and scanned one entry per cycle, so a request
// is accepted, scanned, learned if it is a valid frame, and its result is
// then offered; a new request is taken only after that result has been
// taken. Every request gives exactly one result. own_ip is written
// through cfg_we/cfg_data; the user must do so only while no request is
// in flight, and the block itself does not enforce this. No clearing pass
// is needed after reset.
module arp_cache_and_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire  [arpc_pkg::IP_W-1:0]  cfg_data,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  arpc_pkg::in_t              in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output arpc_pkg::out_t             out_data
);

  arpc_pkg::cmd_t    cmd;
  arpc_pkg::status_t status;

  // sequencer
  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // tables and result
  arpc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("result pending while a new request is accepted");

  // a result never appears in the cycle after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result offered before the table scan");

  // a lookup hit never carries a reply
  a_hit_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.lookup_hit) |-> !out_data.reply_valid)
    else $error("lookup hit and reply in one result");

  // a miss returns a zero mac
  a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.lookup_hit) |-> (out_data.lookup_mac == '0))
    else $error("lookup miss with non-zero mac");

endmodule
`default_nettype wire

// File: design/arpc_ctrl.sv
// arpc_ctrl: sequencing state machine of the arp cache
`default_nettype none
module arpc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  output arpc_pkg::cmd_t    cmd,
  input  arpc_pkg::status_t status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshakes and datapath commands
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    out_valid   = (state_r == S_OUT);
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.scan    = (state_r == S_SCAN);
    cmd.update  = (state_r == S_UPDATE);
  end

endmodule
`default_nettype wire

// File: design/arpc_datapath.sv
// arpc_datapath: cache tables, table scan, learning and result register
`default_nettype none
module arpc_datapath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire  [arpc_pkg::IP_W-1:0]      cfg_data,
  input  arpc_pkg::in_t                  in_data,
  input  arpc_pkg::cmd_t                 cmd,
  output arpc_pkg::status_t              status,
  output arpc_pkg::out_t                 out_data
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = IdxW + 1;
  localparam logic [CntW-1:0] ENTRY_CNT = CntW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LAST_IDX  = IdxW'(TABLE_ENTRIES - 1);

  // table memories, read through registered ports
  logic [arpc_pkg::IP_W-1:0]  addr_mem [TABLE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] hw_mem   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_r;

  logic [arpc_pkg::IP_W-1:0]  own_ip_r;
  arpc_pkg::in_t              req_r;
  arpc_pkg::out_t             res_r;
  arpc_pkg::out_t             res_nxt;

  logic [CntW-1:0]            rd_cnt_r;
  logic                       cmp_vld_r;
  logic [IdxW-1:0]            cmp_idx_r;
  logic [arpc_pkg::IP_W-1:0]  addr_q_r;
  logic [arpc_pkg::MAC_W-1:0] hw_q_r;
  logic                       found_r;
  logic [IdxW-1:0]            hit_idx_r;
  logic [arpc_pkg::MAC_W-1:0] hit_mac_r;
  logic [IdxW-1:0]            victim_r;

  logic                       rd_en;
  logic [arpc_pkg::IP_W-1:0]  key;
  logic                       match;
  logic                       frame_ok;
  logic                       learn;
  logic                       wr_addr_en;
  logic                       wr_hw_en;
  logic [IdxW-1:0]            wr_idx;

  // own address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we) begin
      own_ip_r <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  // search key and decode of the held request
  always_comb begin
    key      = (req_r.kind == arpc_pkg::KIND_LOOKUP) ? req_r.query_ip : req_r.sender_ip;
    frame_ok = (req_r.kind == arpc_pkg::KIND_FRAME) &&
               (req_r.frame_length >= arpc_pkg::MIN_FRAME_LEN);
    learn    = frame_ok && (req_r.sender_ip != '0);
    rd_en    = cmd.scan && (rd_cnt_r < ENTRY_CNT);
    match    = cmp_vld_r && !found_r && valid_r[cmp_idx_r] && (addr_q_r == key);
    status.scan_done = (rd_cnt_r == ENTRY_CNT) && !cmp_vld_r;
  end

  // scan counter and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= rd_en;
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CntW'(1);
      end
      if (match) begin
        found_r <= 1'b1;
      end
    end
  end

  // first matching entry, lowest index wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx_r <= rd_cnt_r[IdxW-1:0];
    end
    if (match) begin
      hit_idx_r <= cmp_idx_r;
      hit_mac_r <= hw_q_r;
    end
  end

  // table write: refresh a hit, otherwise fill the victim slot
  always_comb begin
    wr_addr_en = cmd.update && learn && !found_r;
    wr_hw_en   = cmd.update && learn;
    wr_idx     = found_r ? hit_idx_r : victim_r;
  end

  // table memories
  always_ff @(posedge clk) begin
    if (wr_addr_en) begin
      addr_mem[wr_idx] <= req_r.sender_ip;
    end
    if (wr_hw_en) begin
      hw_mem[wr_idx] <= req_r.sender_mac;
    end
    if (rd_en) begin
      addr_q_r <= addr_mem[rd_cnt_r[IdxW-1:0]];
      hw_q_r   <= hw_mem[rd_cnt_r[IdxW-1:0]];
    end
  end

  // valid bits and round-robin victim pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      victim_r <= '0;
    end else if (wr_addr_en) begin
      valid_r[victim_r] <= 1'b1;
      victim_r <= (victim_r == LAST_IDX) ? '0 : victim_r + IdxW'(1);
    end
  end

  // result
  always_comb begin
    res_nxt = '0;
    if (frame_ok && (req_r.opcode == arpc_pkg::OP_REQUEST) &&
        (req_r.tgt_ip == own_ip_r)) begin
      res_nxt.reply_valid = 1'b1;
      res_nxt.reply_mac   = req_r.sender_mac;
      res_nxt.reply_ip    = req_r.sender_ip;
    end
    if ((req_r.kind == arpc_pkg::KIND_LOOKUP) && found_r) begin
      res_nxt.lookup_hit = 1'b1;
      res_nxt.lookup_mac = hit_mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule
`default_nettype wire
